>>> hw/rtl/sdcu_pkg.sv
`default_nettype none
package sdcu_pkg;

    localparam int MAX_CODES      = 4096;
    localparam int PAYLOAD_BYTES  = 65536;
    localparam int CODE_AW        = $clog2(MAX_CODES);
    localparam int PAY_AW         = $clog2(PAYLOAD_BYTES);
    localparam int DICT_W         = $clog2(MAX_CODES + 2);
    localparam int ENTRY_W        = 8 + PAY_AW;

    localparam logic [15:0] CODE_CLEAR = 16'd256;
    localparam logic [15:0] CODE_STOP  = 16'd257;
    localparam logic [7:0]  LEN_NARROW = 8'd12;
    localparam logic [7:0]  LEN_WIDE   = 8'd16;
    localparam logic [4:0]  HDR_LAST   = 5'd23;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_LEN  = 2'd1,
        ERR_BEYOND   = 2'd2,
        ERR_DICT_BIG = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LOADLEN,
        PH_LOADDATA,
        PH_CODES,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TBL,
        ST_RD,
        ST_CAP,
        ST_EMIT
    } ctl_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] cnt;
        logic       last;
        logic       done;
        err_t       err;
    } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/sdcu_if.sv
`default_nettype none
interface sdcu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;
    modport source (output valid, in_byte, stream_start, input ready);
    modport sink (input valid, in_byte, stream_start, output ready);
endinterface

interface sdcu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;
    logic       stream_done;
    logic [1:0] error_code;
    modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
                    last_of_run, stream_done, error_code, input ready);
    modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
                  last_of_run, stream_done, error_code, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sdcu_ram.sv
`default_nettype none
// Simple dual-port RAM with one write port and a registered read port.
module sdcu_ram #(
    parameter int AW = 12,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/static_dictionary_code_unpacker_top.sv
`default_nettype none
// A header or load byte is absorbed when accepted; a literal, stop or error code gives its result
// on the cycle after acceptance; a dictionary code reads its table entry, then reads and captures
// each string byte in turn and emits one result per group of up to four bytes.
// No new input byte is accepted until the sequencer is idle and the output register is free.
// Reset is asynchronous and active low; it clears control state, the memories are not cleared.
module static_dictionary_code_unpacker_top
    import sdcu_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sdcu_in_if.sink    stream,
    sdcu_out_if.source result
);
    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [4:0]          pc_reg, pc_next;
    logic [DICT_W-1:0]   dict_reg, dict_next;
    logic                wide_reg, wide_next;
    logic [DICT_W-1:0]   lidx_reg, lidx_next;
    logic [7:0]          left_reg, left_next;
    logic [PAY_AW-1:0]   wptr_reg, wptr_next;
    logic [7:0]          held_reg, held_next;
    logic [1:0]          cbp_reg, cbp_next;
    logic                lbad_reg, lbad_next;

    // Emission sequencer state.
    ctl_t                st_reg, st_next;
    logic [PAY_AW-1:0]   rptr_reg, rptr_next;
    logic [7:0]          rem_reg, rem_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [7:0]          slot_reg [4];
    logic [7:0]          slot_next [4];

    // Output register.
    logic                ovalid_reg, ovalid_next;
    result_t             ores_reg, ores_next;

    // Memories.
    logic                tbl_we, pay_we;
    logic [CODE_AW-1:0]  tbl_waddr, tbl_raddr;
    logic [ENTRY_W-1:0]  tbl_wdata, tbl_rdata;
    logic [7:0]          pay_rdata;

    logic                accept, oslot_free;
    logic [20:0]         hdr_acc;
    logic [15:0]         code;
    logic                have_code;
    result_t             res;
    logic                res_load;

    sdcu_ram #(.AW(CODE_AW), .DW(ENTRY_W)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sdcu_ram #(.AW(PAY_AW), .DW(8)) u_pay (
        .clk   (clk),
        .we    (pay_we),
        .waddr (wptr_reg),
        .wdata (stream.in_byte),
        .raddr (rptr_reg),
        .rdata (pay_rdata)
    );

    // The output register can take a new result when it is empty or is being drained.
    assign oslot_free   = !ovalid_reg || result.ready;
    assign stream.ready = (st_reg == ST_IDLE) && oslot_free;
    assign accept       = stream.valid && stream.ready;

    assign result.valid       = ovalid_reg;
    assign result.out_byte0   = ores_reg.b0;
    assign result.out_byte1   = ores_reg.b1;
    assign result.out_byte2   = ores_reg.b2;
    assign result.out_byte3   = ores_reg.b3;
    assign result.byte_count  = ores_reg.cnt;
    assign result.last_of_run = ores_reg.last;
    assign result.stream_done = ores_reg.done;
    assign result.error_code  = ores_reg.err;

    assign tbl_waddr = lidx_reg[CODE_AW-1:0];
    assign tbl_wdata = {stream.in_byte, wptr_reg};
    assign tbl_raddr = code[CODE_AW-1:0];

    always_comb
    begin
        phase_t pe;
        logic [4:0] pce;
        logic [DICT_W-1:0] de;
        logic we_, lbe;
        logic [1:0] cbe;
        logic [7:0] he, b;

        b          = stream.in_byte;
        pe         = phase_reg;
        pce        = pc_reg;
        de         = dict_reg;
        we_        = wide_reg;
        lbe        = lbad_reg;
        cbe        = cbp_reg;
        he         = held_reg;
        lidx_next  = lidx_reg;
        left_next  = left_reg;
        wptr_next  = wptr_reg;
        // A restart only counts when its transaction is actually taken.
        if (accept && stream.stream_start)
        begin
            pe        = PH_HEADER;
            pce       = '0;
            de        = '0;
            we_       = 1'b0;
            lbe       = 1'b0;
            cbe       = '0;
            he        = '0;
            lidx_next = '0;
            left_next = '0;
            wptr_next = '0;
        end
        phase_next = phase_reg;
        pc_next    = pc_reg;
        dict_next  = dict_reg;
        wide_next  = wide_reg;
        lbad_next  = lbad_reg;
        cbp_next   = cbp_reg;
        held_next  = held_reg;
        tbl_we     = 1'b0;
        pay_we     = 1'b0;
        code       = '0;
        have_code  = 1'b0;
        hdr_acc    = {de, b};
        res        = '0;
        res_load   = 1'b0;

        st_next    = st_reg;
        rptr_next  = rptr_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < 4; i++)
        begin
            slot_next[i] = slot_reg[i];
        end

        if (accept)
        begin
            phase_next = pe;
            pc_next    = pce;
            dict_next  = de;
            wide_next  = we_;
            lbad_next  = lbe;
            cbp_next   = cbe;
            held_next  = he;
            unique case (pe)
                PH_HEADER:
                begin
                    if (pce >= 5'd12 && pce <= 5'd15)
                    begin
                        if (hdr_acc > 21'(MAX_CODES))
                        begin
                            dict_next = DICT_W'(MAX_CODES + 1);
                        end
                        else
                        begin
                            dict_next = hdr_acc[DICT_W-1:0];
                        end
                    end
                    else if (pce >= 5'd20 && pce <= 5'd22)
                    begin
                        if (b != 8'd0)
                        begin
                            lbad_next = 1'b1;
                        end
                    end
                    else if (pce == HDR_LAST)
                    begin
                        if (b == LEN_WIDE)
                        begin
                            wide_next = 1'b1;
                        end
                        else if (b != LEN_NARROW)
                        begin
                            lbad_next = 1'b1;
                        end
                    end
                    if (pce < HDR_LAST)
                    begin
                        pc_next = pce + 5'd1;
                    end
                    else
                    begin
                        pc_next = '0;
                        if (lbad_next || dict_next > DICT_W'(MAX_CODES))
                        begin
                            phase_next = PH_HALT;
                            res.last   = 1'b1;
                            res.err    = lbad_next ? ERR_BAD_LEN : ERR_DICT_BIG;
                            res_load   = 1'b1;
                        end
                        else
                        begin
                            lidx_next  = DICT_W'(CODE_STOP) + DICT_W'(1);
                            phase_next = (dict_next > DICT_W'(CODE_STOP) + DICT_W'(1))
                                         ? PH_LOADLEN : PH_CODES;
                        end
                    end
                end
                PH_LOADLEN:
                begin
                    tbl_we = 1'b1;
                    if (b != 8'd0)
                    begin
                        left_next  = b;
                        phase_next = PH_LOADDATA;
                    end
                    else
                    begin
                        lidx_next  = lidx_reg + DICT_W'(1);
                        phase_next = (lidx_next >= de) ? PH_CODES : PH_LOADLEN;
                    end
                end
                PH_LOADDATA:
                begin
                    pay_we    = 1'b1;
                    wptr_next = wptr_reg + PAY_AW'(1);
                    left_next = left_reg - 8'd1;
                    if (left_next == 8'd0)
                    begin
                        lidx_next  = lidx_reg + DICT_W'(1);
                        phase_next = (lidx_next >= de) ? PH_CODES : PH_LOADLEN;
                    end
                end
                PH_CODES:
                begin
                    if (cbe == 2'd0)
                    begin
                        held_next = b;
                        cbp_next  = 2'd1;
                    end
                    else if (we_)
                    begin
                        code      = {he, b};
                        cbp_next  = 2'd0;
                        have_code = 1'b1;
                    end
                    else if (cbe == 2'd1)
                    begin
                        code      = {4'd0, he, b[7:4]};
                        held_next = {4'd0, b[3:0]};
                        cbp_next  = 2'd2;
                        have_code = 1'b1;
                    end
                    else
                    begin
                        code      = {4'd0, he[3:0], b};
                        cbp_next  = 2'd0;
                        have_code = 1'b1;
                    end
                    if (have_code)
                    begin
                        if (code == CODE_STOP)
                        begin
                            phase_next = PH_DONE;
                            res.last   = 1'b1;
                            res.done   = 1'b1;
                            res_load   = 1'b1;
                        end
                        else if (code < CODE_CLEAR)
                        begin
                            res.b0   = code[7:0];
                            res.cnt  = 3'd1;
                            res.last = 1'b1;
                            res_load = 1'b1;
                        end
                        else if (code != CODE_CLEAR)
                        begin
                            if (code >= 16'(de))
                            begin
                                res.last = 1'b1;
                                res.err  = ERR_BEYOND;
                                res_load = 1'b1;
                            end
                            else
                            begin
                                // The table read issued now returns next cycle.
                                st_next = ST_TBL;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (st_reg)
            ST_IDLE:
            begin
            end
            ST_TBL:
            begin
                rptr_next = tbl_rdata[PAY_AW-1:0];
                rem_next  = tbl_rdata[ENTRY_W-1:PAY_AW];
                cnt_next  = '0;
                for (int i = 0; i < 4; i++)
                begin
                    slot_next[i] = '0;
                end
                st_next = (tbl_rdata[ENTRY_W-1:PAY_AW] == 8'd0) ? ST_IDLE : ST_RD;
            end
            ST_RD:
            begin
                // The payload read at rptr_reg is registered at the end of this cycle and captured in ST_CAP.
                st_next = ST_CAP;
            end
            ST_CAP:
            begin
                slot_next[cnt_reg[1:0]] = pay_rdata;
                cnt_next  = cnt_reg + 3'd1;
                rem_next  = rem_reg - 8'd1;
                rptr_next = rptr_reg + PAY_AW'(1);
                st_next   = (rem_next == 8'd0 || cnt_next == 3'd4) ? ST_EMIT : ST_RD;
            end
            ST_EMIT:
            begin
                if (oslot_free)
                begin
                    res.b0   = slot_reg[0];
                    res.b1   = slot_reg[1];
                    res.b2   = slot_reg[2];
                    res.b3   = slot_reg[3];
                    res.cnt  = cnt_reg;
                    res.last = (rem_reg == 8'd0);
                    res_load = 1'b1;
                    cnt_next = '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        slot_next[i] = '0;
                    end
                    st_next = (rem_reg == 8'd0) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        ovalid_next = res_load ? 1'b1 : (result.ready ? 1'b0 : ovalid_reg);
        ores_next   = res_load ? res : ores_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pc_reg     <= '0;
            dict_reg   <= '0;
            wide_reg   <= 1'b0;
            lidx_reg   <= '0;
            left_reg   <= '0;
            wptr_reg   <= '0;
            held_reg   <= '0;
            cbp_reg    <= '0;
            lbad_reg   <= 1'b0;
            st_reg     <= ST_IDLE;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pc_reg     <= pc_next;
            dict_reg   <= dict_next;
            wide_reg   <= wide_next;
            lidx_reg   <= lidx_next;
            left_reg   <= left_next;
            wptr_reg   <= wptr_next;
            held_reg   <= held_next;
            cbp_reg    <= cbp_next;
            lbad_reg   <= lbad_next;
            st_reg     <= st_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers of the sequencer and the output.
    always_ff @(posedge clk)
    begin
        rptr_reg <= rptr_next;
        ores_reg <= ores_next;
        for (int i = 0; i < 4; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end
endmodule
`default_nettype wire
